>>> hw/rtl/bb3_pkg.sv
// Shared types, constants and helper functions for the 3x3 RGB box blur.
// Used by every module of the block; depends on nothing else.
package bb3_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned CFG_W_W       = 11;
  localparam int unsigned CFG_H_W       = 12;
  localparam int unsigned CFG_DATA_W    = 12;
  localparam int unsigned OUT_COL_W     = 10;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned SUM_W         = 12;
  localparam int unsigned FIFO_DEPTH    = 8;

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = CFG_W_W'(1024);
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = CFG_H_W'(1024);

  // Reciprocal of 9 in 16 fractional bits; exact floor for sums up to 2295.
  localparam int unsigned DIV9_MUL   = 7282;
  localparam int unsigned DIV9_SHIFT = 16;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [7:0]           red_out;
    logic [7:0]           green_out;
    logic [7:0]           blue_out;
    logic [OUT_COL_W-1:0] out_col;
    logic [ROW_W-1:0]     out_row;
    logic                 last_of_run;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } sums_t;

  typedef struct packed {
    logic    first_vld;
    result_t first;
    logic    second_vld;
    result_t second;
  } push_t;

  function automatic logic [7:0] div9(logic [SUM_W-1:0] s);
    logic [SUM_W+13-1:0] p;
    p = (SUM_W + 13)'(s) * (SUM_W + 13)'(DIV9_MUL);
    return p[DIV9_SHIFT +: 8];
  endfunction

endpackage

>>> hw/rtl/bb3_line_ram.sv
// Line store memory holding the two previous rows side by side in one word.
// Synchronous read: the data is registered and appears in the cycle after the read. Depends on bb3_pkg.
module bb3_line_ram import bb3_pkg::*; #(
  parameter int unsigned DEPTH = MAX_WIDTH_DEF,
  parameter int unsigned AW    = $clog2(MAX_WIDTH_DEF),
  parameter int unsigned DW    = 48
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/bb3_window.sv
// Six-entry window of the two previous columns and the 3x3 channel sums.
// Depends on bb3_pkg.
module bb3_window import bb3_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  rgb_t  older_i,
  input  rgb_t  prev_i,
  input  rgb_t  px_i,
  output sums_t sums_o
);

  rgb_t win_q [6];
  rgb_t win_d [6];
  rgb_t taps  [9];

  always_comb begin
    win_d = win_q;
    if (shift_i) begin
      win_d[0] = win_q[1];
      win_d[1] = older_i;
      win_d[2] = win_q[3];
      win_d[3] = prev_i;
      win_d[4] = win_q[5];
      win_d[5] = px_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      win_q <= win_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      taps[i] = win_q[i];
    end
    taps[6] = older_i;
    taps[7] = prev_i;
    taps[8] = px_i;
  end

  always_comb begin
    sums_o = '0;
    for (int i = 0; i < 9; i++) begin
      sums_o.r = sums_o.r + SUM_W'(taps[i].r);
      sums_o.g = sums_o.g + SUM_W'(taps[i].g);
      sums_o.b = sums_o.b + SUM_W'(taps[i].b);
    end
  end

endmodule

>>> hw/rtl/bb3_out_fifo.sv
// Result queue that takes up to two results per cycle and gives one beat per cycle while the receiver is ready.
// Depends on bb3_pkg.
module bb3_out_fifo import bb3_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH,
  parameter int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output result_t          out_data_o,
  output logic [CNT_W-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  result_t          mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             wr0_en, wr1_en, pop;
  result_t          wr0_data;
  logic [PW-1:0]    wptr_nx;

  assign wr0_en   = push_i.first_vld | push_i.second_vld;
  assign wr1_en   = push_i.first_vld & push_i.second_vld;
  assign wr0_data = push_i.first_vld ? push_i.first : push_i.second;
  assign wptr_nx  = PW'((PW + 1)'(wptr_q) + (PW + 1)'(1) == (PW + 1)'(DEPTH) ? 0 : wptr_q + 1'b1);
  assign pop      = out_valid_o & out_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q + CNT_W'(wr0_en) + CNT_W'(wr1_en) - CNT_W'(pop);
    if (wr1_en) begin
      wptr_d = (CNT_W'(wptr_nx) + CNT_W'(1) == CNT_W'(DEPTH)) ? '0 : wptr_nx + 1'b1;
    end else if (wr0_en) begin
      wptr_d = wptr_nx;
    end
    if (pop) begin
      rptr_d = (CNT_W'(rptr_q) + CNT_W'(1) == CNT_W'(DEPTH)) ? '0 : rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr0_en) begin
      mem_q[wptr_q] <= wr0_data;
    end
    if (wr1_en) begin
      mem_q[wptr_nx] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rptr_q];
  assign count_o     = count_q;

endmodule

>>> hw/rtl/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, bb3_line_ram, bb3_window and bb3_out_fifo.
//
// Pixels enter in raster order on the in channel, one beat per pixel. Each
// beat gives zero, one or two result beats on the out channel: first the
// interior pixel one row and one column back with each channel the 3x3 mean
// (truncated), then the input pixel itself if it lies on the frame border.
// The last result of an input beat carries last_of_run. Every result carries
// its own column and row.
// An input beat reads the line store in the cycle it is accepted, forms the
// window sums and writes back in the next cycle, and is scaled by one ninth and
// queued in the cycle after that; its results are then offered from the queue.
// One pixel is accepted every cycle while the result queue has room; the line
// store has one read and one write port, and back-to-back pixels in the same
// column are forwarded. Frame size is set through the configuration port, by
// the user only while the block is idle; the block itself does not enforce it.
// Reset zeroes the window and the frame position and restores 1024 x 1024.
// When the receiver stalls, results wait in an eight-entry queue and input
// ready drops once the queue could no longer hold all results in flight.
module box_blur_3x3_rgb import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pixel_in_t             in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_t               out_data_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned WB    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W = (WB > CFG_W_W) ? WB : CFG_W_W;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [CFG_W_W-1:0] width_q;
  logic [CFG_H_W-1:0] height_q;
  logic [AW-1:0]      col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;

  logic [CMP_W-1:0]   w_ext, w_eff, w_last, c_ext;
  logic [ROW_W-1:0]   h_eff, h_last;
  logic               col_last, row_last, interior, border, in_acc;

  logic               s1_valid_q, s1_int_q, s1_bdr_q, fwd_q;
  rgb_t               s1_px_q;
  logic [AW-1:0]      s1_col_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [47:0]        fwd_data_q, rd_data, wr_data;
  rgb_t               prev_rd, older_rd;
  sums_t              sums;

  logic               s2_valid_q, s2_int_q, s2_bdr_q;
  sums_t              s2_sums_q;
  rgb_t               s2_px_q;
  logic [AW-1:0]      s2_col_q;
  logic [ROW_W-1:0]   s2_row_q;
  push_t              push;
  logic [CNT_W-1:0]   fifo_count;
  logic [CNT_W+1:0]   pending;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[CFG_W_W-1:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame position and border classification of the incoming pixel.
  always_comb begin
    w_ext = CMP_W'(width_q);
    if (width_q == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_last   = w_eff - CMP_W'(1);
    h_eff    = (height_q == '0) ? ROW_W'(1) : height_q;
    h_last   = h_eff - ROW_W'(1);
    c_ext    = CMP_W'(col_q);
    col_last = (c_ext >= w_last);
    row_last = (row_q >= h_last);
    interior = (c_ext >= CMP_W'(2)) && (row_q >= ROW_W'(2)) &&
               (c_ext <= w_last) && (row_q <= h_last);
    border   = (col_q == '0) || (row_q == '0) || col_last || row_last;
    col_d    = col_q;
    row_d    = row_q;
    if (in_acc) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pending    = (CNT_W + 2)'(fifo_count) + (CNT_W + 2)'({s1_valid_q, 1'b0}) +
                      (CNT_W + 2)'({s2_valid_q, 1'b0}) + (CNT_W + 2)'(2);
  assign in_ready_o = (pending <= (CNT_W + 2)'(FIFO_DEPTH));
  assign in_acc     = in_valid_i & in_ready_o;

  // Stage 1: line store read returns, window update and write back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q    <= rgb_t'(in_data_i);
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_int_q   <= interior;
      s1_bdr_q   <= border;
      fwd_q      <= s1_valid_q && (s1_col_q == col_q);
      fwd_data_q <= wr_data;
    end
  end

  bb3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (48)
  ) u_line_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data)
  );

  assign older_rd = fwd_q ? rgb_t'(fwd_data_q[47:24]) : rgb_t'(rd_data[47:24]);
  assign prev_rd  = fwd_q ? rgb_t'(fwd_data_q[23:0])  : rgb_t'(rd_data[23:0]);
  assign wr_data  = {prev_rd, s1_px_q};

  bb3_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_valid_q),
    .older_i (older_rd),
    .prev_i  (prev_rd),
    .px_i    (s1_px_q),
    .sums_o  (sums)
  );

  // Stage 2: scale by one ninth and queue the results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_sums_q <= sums;
      s2_px_q   <= s1_px_q;
      s2_col_q  <= s1_col_q;
      s2_row_q  <= s1_row_q;
      s2_int_q  <= s1_int_q;
      s2_bdr_q  <= s1_bdr_q;
    end
  end

  always_comb begin
    push.first_vld          = s2_valid_q & s2_int_q;
    push.first.red_out      = div9(s2_sums_q.r);
    push.first.green_out    = div9(s2_sums_q.g);
    push.first.blue_out     = div9(s2_sums_q.b);
    push.first.out_col      = OUT_COL_W'(s2_col_q - AW'(1));
    push.first.out_row      = s2_row_q - ROW_W'(1);
    push.first.last_of_run  = ~s2_bdr_q;
    push.second_vld         = s2_valid_q & s2_bdr_q;
    push.second.red_out     = s2_px_q.r;
    push.second.green_out   = s2_px_q.g;
    push.second.blue_out    = s2_px_q.b;
    push.second.out_col     = OUT_COL_W'(s2_col_q);
    push.second.out_row     = s2_row_q;
    push.second.last_of_run = 1'b1;
  end

  bb3_out_fifo #(
    .DEPTH (FIFO_DEPTH),
    .CNT_W (CNT_W)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .count_o     (fifo_count)
  );

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_accept_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q && (s1_col_q == $past(col_q)))
    else $error("accepted pixel did not reach stage 1");

  a_credit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (CNT_W + 2)'(fifo_count) + (CNT_W + 2)'({s1_valid_q, 1'b0}) +
               (CNT_W + 2)'({s2_valid_q, 1'b0}) <= (CNT_W + 2)'(FIFO_DEPTH))
    else $error("results in flight exceed queue room");

endmodule

>>> bench/box_blur_3x3_rgb_tb.sv
// Testbench for the streaming 3x3 RGB box blur: sends raster-order frames of many sizes
// and checks every result beat against a behavioral copy of the filter kept in the bench.
// Depends on bb3_pkg and the box_blur_3x3_rgb top level.
module box_blur_3x3_rgb_tb;
  import bb3_pkg::*;

  localparam int unsigned STORE_DEPTH   = MAX_WIDTH_DEF;
  localparam int unsigned NEIGHBORHOOD  = 9;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RANDOM_PIXELS = 200;
  localparam int unsigned MAX_REPORTS   = 40;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  pixel_in_t             in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  result_t               out_data_o;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  box_blur_3x3_rgb DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  rgb_t                 prev_row_px [STORE_DEPTH];
  rgb_t                 older_row_px [STORE_DEPTH];
  rgb_t                 window_px [6];
  logic [OUT_COL_W-1:0] frame_col;
  logic [ROW_W-1:0]     frame_row;
  logic [CFG_W_W-1:0]   width_reg;
  logic [CFG_H_W-1:0]   height_reg;
  result_t              blur_results_q [$];
  result_t              expected_res;

  bit          tx_gaps_en;
  int unsigned rx_stall_pct;
  int unsigned rx_hold;
  int unsigned quiet_cycles;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned frames_run;
  int unsigned err_count;

  function automatic void blur_accept(pixel_in_t p);
    int unsigned w, h, c, r, sum_r, sum_g, sum_b, i;
    int          n;
    rgb_t        column [3];
    rgb_t        v;
    result_t     res [2];
    w = (width_reg == 0) ? 1 : 32'(width_reg);
    if (w > STORE_DEPTH) w = STORE_DEPTH;
    h = (height_reg == 0) ? 1 : 32'(height_reg);
    c = 32'(frame_col);
    r = 32'(frame_row);
    column[0] = older_row_px[c];
    column[1] = prev_row_px[c];
    column[2] = rgb_t'(p);
    n = 0;
    if (c >= 2 && r >= 2 && c <= w - 1 && r <= h - 1) begin
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (i = 0; i < NEIGHBORHOOD; i++) begin
        v = (i < 6) ? window_px[i] : column[i - 6];
        sum_r += 32'(v.r);
        sum_g += 32'(v.g);
        sum_b += 32'(v.b);
      end
      res[n] = '0;
      res[n].red_out   = 8'(sum_r / NEIGHBORHOOD);
      res[n].green_out = 8'(sum_g / NEIGHBORHOOD);
      res[n].blue_out  = 8'(sum_b / NEIGHBORHOOD);
      res[n].out_col   = OUT_COL_W'(c - 1);
      res[n].out_row   = ROW_W'(r - 1);
      n++;
    end
    if (c == 0 || r == 0 || c >= w - 1 || r >= h - 1) begin
      res[n] = '0;
      res[n].red_out   = p.red_in;
      res[n].green_out = p.green_in;
      res[n].blue_out  = p.blue_in;
      res[n].out_col   = OUT_COL_W'(c);
      res[n].out_row   = ROW_W'(r);
      n++;
    end
    if (n > 0) res[n - 1].last_of_run = 1'b1;
    for (i = 0; i < n; i++) blur_results_q.push_back(res[i]);
    older_row_px[c] = column[1];
    prev_row_px[c]  = column[2];
    for (i = 0; i < 3; i++) begin
      window_px[i * 2]     = window_px[i * 2 + 1];
      window_px[i * 2 + 1] = column[i];
    end
    if (c + 1 >= w) begin
      frame_col = '0;
      frame_row = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
    end else begin
      frame_col = OUT_COL_W'(c + 1);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (!tx_gaps_en) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 65) return 0;
    if (sel < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic pixel_in_t rand_pixel();
    logic [23:0] bits;
    pixel_in_t   p;
    bits = 24'($urandom);
    p = bits;
    if ($urandom_range(0, 99) < 15) begin
      p.red_in   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.green_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.blue_in  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  function automatic void compare_field(string field, logic [ROW_W-1:0] want,
                                        logic [ROW_W-1:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s of pixel (%0d,%0d): expected %0d, got %0d", $time, field,
                 expected_res.out_col, expected_res.out_row, want, got);
    end
  endfunction

  task automatic send_pixel(pixel_in_t p);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    blur_accept(p);
    pixels_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (blur_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_IMAGE_WIDTH) width_reg = CFG_W_W'(val);
    else height_reg = CFG_H_W'(val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_rest_of_frame();
    do send_pixel(rand_pixel()); while (frame_col != 0 || frame_row != 0);
  endtask

  task automatic test_reset_size();
    send_pixel(pixel_in_t'(24'h00_0000));
    send_pixel(pixel_in_t'(24'hFF_FFFF));
    send_pixel(rand_pixel());
  endtask

  task automatic test_resize_mid_frame();
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(4));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
    send_rest_of_frame();
  endtask

  task automatic test_sum_extremes();
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    repeat (9) send_pixel(pixel_in_t'(24'hFF_FFFF));
    // A neighborhood summing to eight must truncate to zero.
    repeat (4) send_pixel(pixel_in_t'(24'h01_0101));
    send_pixel(pixel_in_t'(24'h00_0000));
    repeat (4) send_pixel(pixel_in_t'(24'h01_0101));
  endtask

  task automatic test_tallest_frame();
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(12'hFFF));
    repeat (9) send_pixel(rand_pixel());
    drain();
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(4));
    send_rest_of_frame();
  endtask

  task automatic test_zero_width();
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(0));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(2));
    send_rest_of_frame();
  endtask

  task automatic test_widest_row();
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(12'hFFF));
    write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(0));
    repeat (6) send_pixel(rand_pixel());
    drain();
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(3));
    send_rest_of_frame();
  endtask

  task automatic test_random_frames();
    int unsigned first_px, w, h, n, break_at, sel;
    first_px = pixels_sent;
    while (pixels_sent - first_px < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 3);
      tx_gaps_en   = (sel == 1 || sel == 2);
      rx_stall_pct = (sel == 0) ? 0 : (sel == 3) ? 70 : 20;
      sel = $urandom_range(0, 9);
      w = (sel == 0) ? $urandom_range(1, 2) : (sel < 8) ? $urandom_range(3, 10) :
          $urandom_range(11, 40);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      drain();
      write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'((w == 1 && $urandom_range(0, 1)) ? 0 : w));
      write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'((h == 1 && $urandom_range(0, 1)) ? 0 : h));
      break_at = (w * h > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, w * h - 1) : 0;
      n = 0;
      do begin
        send_pixel(rand_pixel());
        n++;
        if (n == break_at) begin
          drain();
          sel = $urandom_range(0, 2);
          if (sel == 1) write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(1, h + 2)));
          else if (sel == 2) write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, w)));
        end
      end while (frame_col != 0 || frame_row != 0);
      frames_run++;
    end
    tx_gaps_en   = 1'b1;
    rx_stall_pct = 20;
  endtask

  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 99) < rx_stall_pct) begin
      out_ready_i <= 1'b0;
      rx_hold     <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (blur_results_q.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected: pixel (%0d,%0d) rgb %0d %0d %0d",
                 $time, out_data_o.out_col, out_data_o.out_row, out_data_o.red_out,
                 out_data_o.green_out, out_data_o.blue_out);
      end else begin
        expected_res = blur_results_q.pop_front();
        compare_field("red_out", ROW_W'(expected_res.red_out), ROW_W'(out_data_o.red_out));
        compare_field("green_out", ROW_W'(expected_res.green_out),
                      ROW_W'(out_data_o.green_out));
        compare_field("blue_out", ROW_W'(expected_res.blue_out), ROW_W'(out_data_o.blue_out));
        compare_field("out_col", ROW_W'(expected_res.out_col), ROW_W'(out_data_o.out_col));
        compare_field("out_row", expected_res.out_row, out_data_o.out_row);
        compare_field("last_of_run", ROW_W'(expected_res.last_of_run),
                      ROW_W'(out_data_o.last_of_run));
        results_seen++;
      end
    end
    if (rst_ni && !(in_valid_i && in_ready_o) && !(out_valid_o && out_ready_i) && !cfg_we_i)
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still expected", $time,
               quiet_cycles, blur_results_q.size());
      $display("box_blur_3x3_rgb_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_IMAGE_WIDTH;
    cfg_data_i   = '0;
    tx_gaps_en   = 1'b1;
    rx_stall_pct = 20;
    foreach (prev_row_px[i]) prev_row_px[i] = '0;
    foreach (older_row_px[i]) older_row_px[i] = '0;
    foreach (window_px[i]) window_px[i] = '0;
    frame_col  = '0;
    frame_row  = '0;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_resize_mid_frame();
    test_sum_extremes();
    test_tallest_frame();
    test_zero_width();
    test_widest_row();
    test_random_frames();
    drain();
    $display("Checked %0d result beats from %0d pixels, %0d of the frames random.",
             results_seen, pixels_sent, frames_run);
    $display("Frames ran from 1x1 to 40 wide and 4095 high, with clamped and changed sizes.");
    if (err_count == 0) begin
      $display("box_blur_3x3_rgb_tb OK");
    end else begin
      $display("box_blur_3x3_rgb_tb NOT OK");
    end
    $finish;
  end

endmodule
